/* rtl/rsfr_pkg.sv */
// Shared types and constants for the RS-485 frame receiver.
package rsfr_pkg;

	// Frame constants.
	localparam logic [7:0] SYNC_BYTE   = 8'h55;
	localparam logic [7:0] BCAST_ADDR  = 8'hff;
	localparam logic [9:0] SILENCE_MAX = 10'h3ff;

	// Input action codes.
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// Result event codes.
	localparam logic [1:0] EV_PAYLOAD = 2'd0;
	localparam logic [1:0] EV_EMPTY   = 2'd1;
	localparam logic [1:0] EV_ABORT   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_LOCAL_ADDR = 2'd0;
	localparam logic [1:0] CFG_MAX_LENGTH = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT_MS = 2'd2;

	// Configuration reset values.
	localparam logic [7:0] RST_LOCAL_ADDR = 8'd1;
	localparam logic [7:0] RST_MAX_LENGTH = 8'd128;
	localparam logic [9:0] RST_TIMEOUT_MS = 10'd100;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] local_address;
		logic [7:0] max_length;
		logic [9:0] timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [7:0] source_address;
		logic       to_broadcast;
		logic       last;
	} result_t;

endpackage

/* rtl/rsfr_in_reg.sv */
// Input register stage that holds one accepted transaction until it is processed.
module rsfr_in_reg import rsfr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t item_in,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	// The stage can take a new transaction when empty or when its item leaves.
	assign in_ready = !valid_s1 || advance;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_in;
		end
	end

endmodule

/* rtl/rsfr_core.sv */
// Deframer state and the combinational update that handles one item.
module rsfr_core import rsfr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item_s1,
	input  logic    advance,
	output logic    res_valid,
	output result_t res
);

	logic       in_payload_q,       in_payload_d;
	logic [1:0] header_count_q,     header_count_d;
	logic [7:0] sync_seen_q,        sync_seen_d;
	logic [7:0] dest_seen_q,        dest_seen_d;
	logic [7:0] src_seen_q,         src_seen_d;
	logic [7:0] payload_length_q,   payload_length_d;
	logic [7:0] payload_position_q, payload_position_d;
	logic [9:0] silence_ms_q,       silence_ms_d;

	logic [9:0] silence_inc;
	logic [8:0] position_inc;
	logic       is_last;
	logic       header_ok;

	// Helper terms for the tick and payload paths.
	assign silence_inc  = (silence_ms_q == SILENCE_MAX) ? silence_ms_q : silence_ms_q + 10'd1;
	assign position_inc = {1'b0, payload_position_q} + 9'd1;
	assign is_last      = position_inc >= {1'b0, payload_length_q};
	assign header_ok    = (sync_seen_q == SYNC_BYTE)
		&& ((dest_seen_q == BCAST_ADDR) || (dest_seen_q == cfg.local_address))
		&& (item_s1.rx_byte <= cfg.max_length);

	// Next state and result for the item in the input stage.
	always_comb begin
		in_payload_d       = in_payload_q;
		header_count_d     = header_count_q;
		sync_seen_d        = sync_seen_q;
		dest_seen_d        = dest_seen_q;
		src_seen_d         = src_seen_q;
		payload_length_d   = payload_length_q;
		payload_position_d = payload_position_q;
		silence_ms_d       = silence_ms_q;
		res_valid          = 1'b0;
		res.event_res      = EV_PAYLOAD;
		res.data_byte      = 8'd0;
		res.byte_index     = 8'd0;
		res.source_address = src_seen_q;
		res.to_broadcast   = (dest_seen_q == BCAST_ADDR);
		res.last           = 1'b1;

		if (item_s1.action == ACT_TICK) begin
			// Ticks only count silence while a frame is open.
			if (!in_payload_q && header_count_q == 2'd0) begin
				silence_ms_d = 10'd0;
			end else if (silence_inc >= cfg.timeout_ms) begin
				if (in_payload_q) begin
					res_valid      = 1'b1;
					res.event_res  = EV_ABORT;
					res.byte_index = payload_position_q;
				end
				in_payload_d       = 1'b0;
				header_count_d     = 2'd0;
				payload_position_d = 8'd0;
				silence_ms_d       = 10'd0;
			end else begin
				silence_ms_d = silence_inc;
			end
		end else begin
			silence_ms_d = 10'd0;
			if (in_payload_q) begin
				// Payload byte: emit it and close the frame after the last one.
				res_valid          = 1'b1;
				res.event_res      = EV_PAYLOAD;
				res.data_byte      = item_s1.rx_byte;
				res.byte_index     = payload_position_q;
				res.last           = is_last;
				payload_position_d = position_inc[7:0];
				if (is_last) begin
					in_payload_d       = 1'b0;
					header_count_d     = 2'd0;
					payload_position_d = 8'd0;
				end
			end else begin
				// Header collection; the length byte checks sync, destination and its own limit.
				case (header_count_q)
					2'd0: begin
						sync_seen_d    = item_s1.rx_byte;
						header_count_d = 2'd1;
					end
					2'd1: begin
						dest_seen_d    = item_s1.rx_byte;
						header_count_d = 2'd2;
					end
					2'd2: begin
						src_seen_d     = item_s1.rx_byte;
						header_count_d = 2'd3;
					end
					default: begin
						payload_length_d   = item_s1.rx_byte;
						header_count_d     = 2'd0;
						payload_position_d = 8'd0;
						if (header_ok) begin
							if (item_s1.rx_byte == 8'd0) begin
								res_valid     = 1'b1;
								res.event_res = EV_EMPTY;
							end else begin
								in_payload_d = 1'b1;
							end
						end
					end
				endcase
			end
		end
	end

	// Frame state registers, updated when the item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q       <= 1'b0;
			header_count_q     <= 2'd0;
			sync_seen_q        <= 8'd0;
			dest_seen_q        <= 8'd0;
			src_seen_q         <= 8'd0;
			payload_length_q   <= 8'd0;
			payload_position_q <= 8'd0;
			silence_ms_q       <= 10'd0;
		end else if (advance) begin
			in_payload_q       <= in_payload_d;
			header_count_q     <= header_count_d;
			sync_seen_q        <= sync_seen_d;
			dest_seen_q        <= dest_seen_d;
			src_seen_q         <= src_seen_d;
			payload_length_q   <= payload_length_d;
			payload_position_q <= payload_position_d;
			silence_ms_q       <= silence_ms_d;
		end
	end

endmodule

/* rtl/rsfr_out_reg.sv */
// Result register that holds one result until the output transaction completes.
module rsfr_out_reg import rsfr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_q
);

	// The register can load when empty or when its result is taken now.
	assign free = !out_valid || out_ready;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res_in;
		end
	end

endmodule

/* rtl/rs485_frame_receiver.sv */
// Top level of the RS-485 frame receiver: configuration, stages and checks.
// Usage:
//   The input channel (in_valid/in_ready) carries one transaction per received
//   byte (action 0, rx_byte) or per one millisecond tick (action 1). The output
//   channel (out_valid/out_ready) carries payload bytes with their index, the
//   empty frame event and the timeout abort event, each with the header source
//   address and a broadcast flag; last marks the final result of a frame.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Data path:
//   An input transaction lands in the input register and is processed there by
//   the combinational deframer update; its result, if any, is loaded into the
//   result register when the item advances, and out_valid then rises. One
//   transaction per cycle is taken while no result waits on out_ready.
// Reset:
//   arst_n clears both stages and the frame state and loads local_address 1,
//   max_length 128 and timeout_ms 100.
// Stall:
//   While out_ready is low a held result stays in place; an item that would
//   make a result waits in the input register and in_ready drops. Items that
//   make no result still pass while the output waits.
module rs485_frame_receiver import rsfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_res,
	output logic [7:0] data_byte,
	output logic [7:0] byte_index,
	output logic [7:0] source_address,
	output logic       to_broadcast,
	output logic       last
);

	cfg_t    cfg_q;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    res_valid;
	logic    out_free;
	result_t res;
	result_t res_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_address <= RST_LOCAL_ADDR;
			cfg_q.max_length    <= RST_MAX_LENGTH;
			cfg_q.timeout_ms    <= RST_TIMEOUT_MS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOCAL_ADDR: cfg_q.local_address <= cfg_data[7:0];
				CFG_MAX_LENGTH: cfg_q.max_length    <= cfg_data[7:0];
				CFG_TIMEOUT_MS: cfg_q.timeout_ms    <= cfg_data;
				default: ;
			endcase
		end
	end

	// The stored item is processed when its result, if any, has room.
	assign item_in.action  = action;
	assign item_in.rx_byte = rx_byte;
	assign advance         = valid_s1 && (!res_valid || out_free);

	rsfr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item_in  (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rsfr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_s1   (item_s1),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	rsfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res_in    (res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	// Output fields.
	assign event_res      = res_q.event_res;
	assign data_byte      = res_q.data_byte;
	assign byte_index     = res_q.byte_index;
	assign source_address = res_q.source_address;
	assign to_broadcast   = res_q.to_broadcast;
	assign last           = res_q.last;

	// An accepted transaction always occupies the input register next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted transaction did not reach the input register");

	// A processed item with a result shows up on the output next cycle.
	a_result_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid |=> out_valid)
		else $error("result was lost between core and result register");

	// Only defined event codes leave the block.
	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_res == EV_PAYLOAD || event_res == EV_EMPTY
			|| event_res == EV_ABORT))
		else $error("undefined event code on output");

	// Empty frame and abort events always close their frame.
	a_event_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_PAYLOAD |-> last && data_byte == 8'd0)
		else $error("frame event without last flag or with data");

endmodule
